>>> rtl/elevation_post_bilinear_interp_core_macros.svh
`ifndef ELEVATION_POST_BILINEAR_INTERP_CORE_MACROS_SVH
`define ELEVATION_POST_BILINEAR_INTERP_CORE_MACROS_SVH

// Clocked assertion with a reset that disables the check.
`define EPBI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Overlapping implication built on the plain clocked assertion.
`define EPBI_ASSERT_IMPLY(label, clk, rst, cond, conseq, msg) \
  `EPBI_ASSERT(label, clk, rst, (cond) |-> (conseq), msg)

`endif

>>> rtl/epbi_pkg.sv
`default_nettype none

package epbi_pkg;

  localparam int POST_W        = 16;
  localparam int FRAC_W        = 16;
  localparam int ELEV_W        = 31;
  localparam int OUT_FRAC      = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Number of register stages between an accepted request and its result.
  localparam int PIPE_DEPTH = 6;

  localparam logic [POST_W-1:0]        POST_NULL = 16'hFFFF;
  localparam logic signed [POST_W-1:0] ELEV_MIN  = -16'sd12000;
  localparam logic signed [POST_W-1:0] ELEV_MAX  = 16'sd9000;

  // One decoded post: its value in metres and whether it may be used.
  typedef struct packed {
    logic                     ok;
    logic signed [POST_W-1:0] value;
  } post_t;

endpackage

`default_nettype wire

>>> rtl/elevation_post_bilinear_interp_core.sv
`default_nettype none

// Bilinear elevation interpolation over one terrain cell. A request is
// accepted on every clock edge at which start is high; busy is always low,
// so a new request may be issued in every cycle. Each request produces
// exactly one result: done is high for one cycle and elevation and
// elevation_valid are meaningful during that cycle only. The receiver
// cannot stall the block, so it must take each result as it appears. The
// pipeline has six register stages (post decode, east-west products, edge
// sums, edge difference, north-south product, final add and scaling), and
// its multipliers and wide adds sit in separate stages. Results come out
// in request order. When two or more posts are null, or out of range,
// elevation_valid is low and elevation reads zero. With exactly one null
// post, its edge uses the other post of that edge.
module elevation_post_bilinear_interp_core #(
  parameter int FRAC_BITS = epbi_pkg::FRAC_BITS_DEF
) (
  input  wire  logic                               clk,
  input  wire  logic                               rst,
  input  wire  logic                               start,
  output logic                                     busy,
  input  wire  logic [epbi_pkg::POST_W-1:0]        south_west_raw,
  input  wire  logic [epbi_pkg::POST_W-1:0]        north_west_raw,
  input  wire  logic [epbi_pkg::POST_W-1:0]        south_east_raw,
  input  wire  logic [epbi_pkg::POST_W-1:0]        north_east_raw,
  input  wire  logic [epbi_pkg::FRAC_W-1:0]        x_fraction,
  input  wire  logic [epbi_pkg::FRAC_W-1:0]        y_fraction,
  output logic                                     done,
  output logic signed [epbi_pkg::ELEV_W-1:0]       elevation,
  output logic                                     elevation_valid
);

  localparam int PW = epbi_pkg::POST_W;
  localparam int FW = epbi_pkg::FRAC_W;
  // Post difference times fraction, both as signed values one bit wider.
  localparam int XPROD_W = 2 * (PW + 1);
  // Edge values at Q.FRAC_BITS; one bit of margin over the largest term.
  localparam int EDGE_W = ((FRAC_BITS + PW > XPROD_W) ? FRAC_BITS + PW : XPROD_W) + 1;
  localparam int DIFF_W = EDGE_W + 1;
  localparam int YPROD_W = DIFF_W + FW + 1;
  localparam int SUM_W = YPROD_W + 1;
  localparam int SH_R = (FRAC_BITS > epbi_pkg::OUT_FRAC) ?
                        FRAC_BITS - epbi_pkg::OUT_FRAC : 0;
  localparam int SH_L = (FRAC_BITS < epbi_pkg::OUT_FRAC) ?
                        epbi_pkg::OUT_FRAC - FRAC_BITS : 0;

  // The pipeline never stalls, so requests are always taken.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Valid bits travel alongside the data, one per stage.
  logic [epbi_pkg::PIPE_DEPTH-1:0] valid_pipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else begin
      valid_pipe <= {valid_pipe[epbi_pkg::PIPE_DEPTH-2:0], accept};
    end
  end

  assign done = valid_pipe[epbi_pkg::PIPE_DEPTH-1];

  // Stage 1: decode posts, replace a single null post by its edge partner.
  epbi_pkg::post_t dec_sw, dec_nw, dec_se, dec_ne;

  epbi_post_decode u_dec_sw (.raw(south_west_raw), .post(dec_sw));
  epbi_post_decode u_dec_nw (.raw(north_west_raw), .post(dec_nw));
  epbi_post_decode u_dec_se (.raw(south_east_raw), .post(dec_se));
  epbi_post_decode u_dec_ne (.raw(north_east_raw), .post(dec_ne));

  logic [2:0] null_count;
  assign null_count = {2'b00, !dec_sw.ok} + {2'b00, !dec_nw.ok} +
                      {2'b00, !dec_se.ok} + {2'b00, !dec_ne.ok};

  logic signed [PW-1:0] s1_sw, s1_nw, s1_se, s1_ne;
  logic [FW-1:0]        s1_xf, s1_yf;
  logic                 s1_ok;

  // Substituting the partner makes the edge interpolate between two equal
  // posts, which yields exactly that post at Q.FRAC_BITS.
  always_ff @(posedge clk) begin
    s1_sw <= dec_sw.ok ? dec_sw.value : dec_se.value;
    s1_se <= dec_se.ok ? dec_se.value : dec_sw.value;
    s1_nw <= dec_nw.ok ? dec_nw.value : dec_ne.value;
    s1_ne <= dec_ne.ok ? dec_ne.value : dec_nw.value;
    s1_xf <= x_fraction;
    s1_yf <= y_fraction;
    s1_ok <= (null_count <= 3'd1);
  end

  // Stage 2: east-west products along both edges.
  logic signed [PW:0]        dx_s, dx_n;
  logic signed [FW:0]        xf_s;
  logic signed [XPROD_W-1:0] s2_prod_s, s2_prod_n;
  logic signed [PW-1:0]      s2_sw, s2_nw;
  logic [FW-1:0]             s2_yf;
  logic                      s2_ok;

  always_comb begin
    dx_s = $signed({s1_se[PW-1], s1_se}) - $signed({s1_sw[PW-1], s1_sw});
    dx_n = $signed({s1_ne[PW-1], s1_ne}) - $signed({s1_nw[PW-1], s1_nw});
    xf_s = $signed({1'b0, s1_xf});
  end

  always_ff @(posedge clk) begin
    s2_prod_s <= dx_s * xf_s;
    s2_prod_n <= dx_n * xf_s;
    s2_sw     <= s1_sw;
    s2_nw     <= s1_nw;
    s2_yf     <= s1_yf;
    s2_ok     <= s1_ok;
  end

  // Stage 3: edge values = west post at Q.FRAC_BITS plus the product.
  logic signed [EDGE_W-1:0] base_s, base_n, ext_s, ext_n;
  logic signed [EDGE_W-1:0] s3_mids, s3_midn;
  logic [FW-1:0]            s3_yf;
  logic                     s3_ok;

  always_comb begin
    base_s = $signed({{(EDGE_W-PW){s2_sw[PW-1]}}, s2_sw}) <<< FRAC_BITS;
    base_n = $signed({{(EDGE_W-PW){s2_nw[PW-1]}}, s2_nw}) <<< FRAC_BITS;
    ext_s  = $signed({{(EDGE_W-XPROD_W){s2_prod_s[XPROD_W-1]}}, s2_prod_s});
    ext_n  = $signed({{(EDGE_W-XPROD_W){s2_prod_n[XPROD_W-1]}}, s2_prod_n});
  end

  always_ff @(posedge clk) begin
    s3_mids <= base_s + ext_s;
    s3_midn <= base_n + ext_n;
    s3_yf   <= s2_yf;
    s3_ok   <= s2_ok;
  end

  // Stage 4: north minus south edge.
  logic signed [DIFF_W-1:0] s4_diff;
  logic signed [EDGE_W-1:0] s4_mids;
  logic [FW-1:0]            s4_yf;
  logic                     s4_ok;

  always_ff @(posedge clk) begin
    s4_diff <= $signed({s3_midn[EDGE_W-1], s3_midn}) -
               $signed({s3_mids[EDGE_W-1], s3_mids});
    s4_mids <= s3_mids;
    s4_yf   <= s3_yf;
    s4_ok   <= s3_ok;
  end

  // Stage 5: north-south product.
  logic signed [FW:0]        yf_s;
  logic signed [YPROD_W-1:0] s5_prod;
  logic signed [EDGE_W-1:0]  s5_mids;
  logic                      s5_ok;

  assign yf_s = $signed({1'b0, s4_yf});

  always_ff @(posedge clk) begin
    s5_prod <= s4_diff * yf_s;
    s5_mids <= s4_mids;
    s5_ok   <= s4_ok;
  end

  // Stage 6: floor the product back to Q.FRAC_BITS, add, bring to Q.16.
  logic signed [YPROD_W-1:0] step;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   scaled;

  always_comb begin
    step   = s5_prod >>> FRAC_BITS;
    sum    = $signed({{(SUM_W-EDGE_W){s5_mids[EDGE_W-1]}}, s5_mids}) +
             $signed({step[YPROD_W-1], step});
    scaled = (sum >>> SH_R) <<< SH_L;
  end

  always_ff @(posedge clk) begin
    elevation       <= s5_ok ? $signed(scaled[epbi_pkg::ELEV_W-1:0]) : '0;
    elevation_valid <= s5_ok;
  end

endmodule

`default_nettype wire

>>> rtl/epbi_post_decode.sv
`default_nettype none

// Decodes one sign-magnitude post and flags it as null when it carries the
// null code or lies outside the legal elevation range.
module epbi_post_decode (
  input  wire logic [epbi_pkg::POST_W-1:0] raw,
  output epbi_pkg::post_t                  post
);

  logic [epbi_pkg::POST_W-1:0] mag;
  logic signed [epbi_pkg::POST_W-1:0] value;

  always_comb begin
    mag = {1'b0, raw[epbi_pkg::POST_W-2:0]};
    if (raw[epbi_pkg::POST_W-1]) begin
      value = $signed(-mag);
    end else begin
      value = $signed(mag);
    end
    post.value = value;
    post.ok    = (raw != epbi_pkg::POST_NULL) &&
                 (value >= epbi_pkg::ELEV_MIN) && (value <= epbi_pkg::ELEV_MAX);
  end

endmodule

`default_nettype wire

>>> rtl/epbi_checker.sv
`default_nettype none

`include "elevation_post_bilinear_interp_core_macros.svh"

// Watches the ports of the interpolation core.
module epbi_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic [epbi_pkg::POST_W-1:0]         south_west_raw,
  input wire logic [epbi_pkg::POST_W-1:0]         north_west_raw,
  input wire logic [epbi_pkg::POST_W-1:0]         south_east_raw,
  input wire logic [epbi_pkg::POST_W-1:0]         north_east_raw,
  input wire logic [epbi_pkg::FRAC_W-1:0]         x_fraction,
  input wire logic [epbi_pkg::FRAC_W-1:0]         y_fraction,
  input wire logic                                done,
  input wire logic signed [epbi_pkg::ELEV_W-1:0]  elevation,
  input wire logic                                elevation_valid
);

  localparam int DEPTH = epbi_pkg::PIPE_DEPTH;

  logic unused_ok;
  assign unused_ok = ^{south_east_raw, north_east_raw, x_fraction, y_fraction};

  // A request is taken, and both west posts carry the null code.
  logic req;
  logic west_null;
  assign req       = start && !busy;
  assign west_null = (south_west_raw == epbi_pkg::POST_NULL) &&
                     (north_west_raw == epbi_pkg::POST_NULL);

  `EPBI_ASSERT_IMPLY(a_req_gives_result, clk, rst, req, ##DEPTH done, "request gave no result")
  `EPBI_ASSERT_IMPLY(a_result_has_req, clk, rst, done, $past(req, DEPTH), "result without request")
  `EPBI_ASSERT_IMPLY(a_two_null_invalid, clk, rst, req && west_null, ##DEPTH (done && !elevation_valid), "two nulls gave valid")
  `EPBI_ASSERT_IMPLY(a_invalid_zero, clk, rst, done && !elevation_valid, elevation == '0, "invalid result not zero")

endmodule

bind elevation_post_bilinear_interp_core epbi_checker u_epbi_checker (.*);

`default_nettype wire

>>> bench/tb_elevation_post_bilinear_interp_core.sv
`timescale 1ns / 100ps

// Self-checking bench for the bilinear elevation interpolation core.
module tb_elevation_post_bilinear_interp_core;

  localparam int POST_W     = epbi_pkg::POST_W;
  localparam int FRAC_W     = epbi_pkg::FRAC_W;
  localparam int ELEV_W     = epbi_pkg::ELEV_W;
  localparam int OUT_FRAC   = epbi_pkg::OUT_FRAC;
  localparam int PIPE_DEPTH = epbi_pkg::PIPE_DEPTH;
  localparam logic [POST_W-1:0]        POST_NULL = epbi_pkg::POST_NULL;
  localparam logic signed [POST_W-1:0] ELEV_MIN  = epbi_pkg::ELEV_MIN;
  localparam logic signed [POST_W-1:0] ELEV_MAX  = epbi_pkg::ELEV_MAX;

  localparam int FRAC_BITS = epbi_pkg::FRAC_BITS_DEF;
  // The run is cut off here.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_QUERIES = 800;
  // The sender stops at these request counts and lets every result drain first.
  localparam int DRAIN_POINT_A = 300;
  localparam int DRAIN_POINT_B = 610;

  // Raw posts used by the directed part, in sign-magnitude form.
  localparam logic [POST_W-1:0] RAW_ZERO     = 16'h0000;
  localparam logic [POST_W-1:0] RAW_NEG_ZERO = 16'h8000;
  localparam logic [POST_W-1:0] RAW_TOP      = 16'h2328;  // +9000 m
  localparam logic [POST_W-1:0] RAW_BOTTOM   = 16'hAEE0;  // -12000 m
  localparam logic [POST_W-1:0] RAW_OVER     = 16'h2329;  // +9001 m
  localparam logic [POST_W-1:0] RAW_UNDER    = 16'hAEE1;  // -12001 m
  localparam logic [POST_W-1:0] RAW_MAX_MAG  = 16'h7FFF;  // +32767 m
  localparam logic [POST_W-1:0] RAW_NEG_BIG  = 16'hFFFE;  // -32766 m

  // One terrain query as it goes onto the ports.
  typedef struct {
    logic [POST_W-1:0] sw;
    logic [POST_W-1:0] nw;
    logic [POST_W-1:0] se;
    logic [POST_W-1:0] ne;
    logic [FRAC_W-1:0] xf;
    logic [FRAC_W-1:0] yf;
  } terrain_query_t;

  // The elevation that a query must produce.
  typedef struct {
    logic signed [ELEV_W-1:0] elev;
    logic                     ok;
  } elevation_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [POST_W-1:0] south_west_raw = '0;
  logic [POST_W-1:0] north_west_raw = '0;
  logic [POST_W-1:0] south_east_raw = '0;
  logic [POST_W-1:0] north_east_raw = '0;
  logic [FRAC_W-1:0] x_fraction = '0;
  logic [FRAC_W-1:0] y_fraction = '0;
  logic done;
  logic signed [ELEV_W-1:0] elevation;
  logic elevation_valid;

  terrain_query_t query_q[$];
  elevation_t     elevation_q[$];
  terrain_query_t held_query;

  // Both counters change only through nonblocking assignments, so any process
  // that reads them at a clock edge sees the value from before that edge.
  int accepted_total = 0;
  int results_in = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int total_queries;
  int idle_left = 0;
  int burst_left = 0;

  elevation_post_bilinear_interp_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .south_west_raw(south_west_raw),
    .north_west_raw(north_west_raw),
    .south_east_raw(south_east_raw),
    .north_east_raw(north_east_raw),
    .x_fraction(x_fraction),
    .y_fraction(y_fraction),
    .done(done),
    .elevation(elevation),
    .elevation_valid(elevation_valid)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A post is sign-magnitude in metres. It may be used unless it is the null
  // code or its value lies outside the range of real terrain.
  function automatic bit decode_post(input logic [POST_W-1:0] raw, output longint metres);
    longint mag;
    mag = longint'(raw[POST_W-2:0]);
    metres = raw[POST_W-1] ? -mag : mag;
    return (raw != POST_NULL) && (metres >= longint'(ELEV_MIN))
        && (metres <= longint'(ELEV_MAX));
  endfunction

  // Interpolation along one edge, exact at FRAC_BITS fractional bits.
  function automatic longint edge_blend(longint west, longint east, longint frac);
    return west * (longint'(1) << FRAC_BITS) + (east - west) * frac;
  endfunction

  function automatic elevation_t interpolate_elevation(terrain_query_t q);
    longint sw, nw, se, ne, xf, yf, one, mids, midn, r;
    bit vsw, vnw, vse, vne;
    elevation_t res;
    vsw = decode_post(q.sw, sw);
    vnw = decode_post(q.nw, nw);
    vse = decode_post(q.se, se);
    vne = decode_post(q.ne, ne);
    xf = longint'(q.xf);
    yf = longint'(q.yf);
    one = longint'(1) << FRAC_BITS;
    res.elev = '0;
    res.ok = 1'b0;
    // With one null post, its edge collapses onto the other post of that edge.
    if (vsw && vnw && vse && vne) begin
      mids = edge_blend(sw, se, xf);
      midn = edge_blend(nw, ne, xf);
    end else if (!vnw && vne && vse && vsw) begin
      mids = edge_blend(sw, se, xf);
      midn = ne * one;
    end else if (vnw && !vne && vse && vsw) begin
      mids = edge_blend(sw, se, xf);
      midn = nw * one;
    end else if (vnw && vne && !vse && vsw) begin
      mids = sw * one;
      midn = edge_blend(nw, ne, xf);
    end else if (vnw && vne && vse && !vsw) begin
      mids = se * one;
      midn = edge_blend(nw, ne, xf);
    end else begin
      return res;
    end
    // Arithmetic shifts of signed values round toward minus infinity.
    r = mids + (((midn - mids) * yf) >>> FRAC_BITS);
    if (FRAC_BITS > OUT_FRAC) begin
      r = r >>> (FRAC_BITS - OUT_FRAC);
    end else begin
      r = r * (longint'(1) << (OUT_FRAC - FRAC_BITS));
    end
    res.elev = r[ELEV_W-1:0];
    res.ok = 1'b1;
    return res;
  endfunction

  function automatic logic [POST_W-1:0] encode_post(int metres, bit neg_zero);
    if (metres < 0) begin
      return {1'b1, 15'(-metres)};
    end
    if (metres == 0 && neg_zero) begin
      return RAW_NEG_ZERO;
    end
    return {1'b0, 15'(metres)};
  endfunction

  // A usable post, leaning toward the ends of the range and toward zero.
  function automatic logic [POST_W-1:0] usable_post();
    int metres;
    case ($urandom_range(19))
      0: metres = int'(ELEV_MIN);
      1: metres = int'(ELEV_MAX);
      2: metres = 0;
      default: metres = int'($urandom_range(21000)) - 12000;
    endcase
    return encode_post(metres, 1'($urandom_range(1)));
  endfunction

  // A post that is null or out of range, or now and then any raw word at all.
  function automatic logic [POST_W-1:0] unusable_post();
    case ($urandom_range(3))
      0: return POST_NULL;
      1: return {1'b0, 15'(9001 + $urandom_range(23766))};
      2: return {1'b1, 15'(12001 + $urandom_range(20766))};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] random_fraction();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_query(logic [POST_W-1:0] sw, logic [POST_W-1:0] nw,
                           logic [POST_W-1:0] se, logic [POST_W-1:0] ne,
                           logic [FRAC_W-1:0] xf, logic [FRAC_W-1:0] yf);
    terrain_query_t q;
    q.sw = sw;
    q.nw = nw;
    q.se = se;
    q.ne = ne;
    q.xf = xf;
    q.yf = yf;
    query_q = {query_q, q};
  endtask

  // Most queries are full cells with random content. The rest lose one post,
  // lose several, or carry raw words with no structure at all.
  task automatic add_random_query();
    logic [POST_W-1:0] p [4];
    int kind;
    int hole;
    kind = $urandom_range(99);
    for (int i = 0; i < 4; i++) begin
      p[i] = usable_post();
    end
    if (kind >= 95) begin
      for (int i = 0; i < 4; i++) begin
        p[i] = 16'($urandom);
      end
    end else if (kind >= 85) begin
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(1) == 1) begin
          p[i] = unusable_post();
        end
      end
      hole = $urandom_range(3);
      p[hole] = unusable_post();
      p[(hole + 1 + $urandom_range(2)) % 4] = unusable_post();
    end else if (kind >= 60) begin
      p[$urandom_range(3)] = unusable_post();
    end
    add_query(p[0], p[1], p[2], p[3], random_fraction(), random_fraction());
  endtask

  // Gap after each request: mostly none or short, a few long, and now and
  // then a burst of back-to-back requests.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(99) < 4) begin
      burst_left = $urandom_range(80, 20);
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(3, 1);
    end else if (roll < 97) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(80, 30);
  endfunction

  // Driver. A request is taken at an edge where start is high and busy low.
  // The expectation for it is computed at that edge, and the next query from
  // the pending queue goes onto the ports once its gap has run out.
  always @(posedge clk) begin
    bit took;
    int after;
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      after = accepted_total + int'(took);
      if (took) begin
        elevation_q = {elevation_q, interpolate_elevation(held_query)};
        accepted_total <= after;
      end
      if (took || !start) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if ((after == DRAIN_POINT_A || after == DRAIN_POINT_B)
                     && results_in != after) begin
          // Hold off until the pipeline has emptied completely.
          start <= 1'b0;
        end else if (query_q.size() != 0) begin
          held_query = query_q.pop_front();
          south_west_raw <= held_query.sw;
          north_west_raw <= held_query.nw;
          south_east_raw <= held_query.se;
          north_east_raw <= held_query.ne;
          x_fraction <= held_query.xf;
          y_fraction <= held_query.yf;
          start <= 1'b1;
          idle_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every done pulse is matched against the oldest expectation.
  always @(posedge clk) begin
    elevation_t want;
    if (!rst && done) begin
      if (elevation_q.size() == 0) begin
        $error("result with no request outstanding: elevation %0d, valid %0b",
               elevation, elevation_valid);
        mismatches++;
      end else begin
        want = elevation_q.pop_front();
        if (elevation !== want.elev) begin
          $error("elevation mismatch: expected %0d, actual %0d", want.elev, elevation);
          mismatches++;
        end
        if (elevation_valid !== want.ok) begin
          $error("elevation_valid mismatch: expected %0b, actual %0b",
                 want.ok, elevation_valid);
          mismatches++;
        end
      end
      results_in <= results_in + 1;
    end
  end

  // Watchdog against a hung pipeline or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    // Directed part: range ends, negative zero, each single null post in each
    // corner, null by code and by range, several nulls, and fractions at the
    // ends so that truncation of negative products shows up.
    add_query(RAW_ZERO, RAW_ZERO, RAW_ZERO, RAW_ZERO, 16'h0000, 16'h0000);
    add_query(RAW_NEG_ZERO, RAW_NEG_ZERO, RAW_NEG_ZERO, RAW_NEG_ZERO, 16'hFFFF, 16'hFFFF);
    add_query(RAW_TOP, RAW_TOP, RAW_TOP, RAW_TOP, 16'hFFFF, 16'h0000);
    add_query(RAW_BOTTOM, RAW_BOTTOM, RAW_BOTTOM, RAW_BOTTOM, 16'h0000, 16'hFFFF);
    add_query(RAW_BOTTOM, RAW_TOP, RAW_TOP, RAW_BOTTOM, 16'hFFFF, 16'h8000);
    add_query(RAW_TOP, RAW_BOTTOM, RAW_BOTTOM, RAW_TOP, 16'h8000, 16'hFFFF);
    add_query(16'h8001, RAW_ZERO, 16'h0001, 16'h8003, 16'h5555, 16'hAAAA);
    add_query(16'h1234, 16'h8456, 16'h2000, 16'h8FFF, 16'h0001, 16'hFFFE);
    add_query(RAW_BOTTOM, POST_NULL, RAW_TOP, RAW_NEG_ZERO, 16'h7FFF, 16'hC000);
    add_query(16'h0100, RAW_TOP, RAW_BOTTOM, RAW_OVER, 16'hFFFF, 16'h3333);
    add_query(RAW_TOP, RAW_BOTTOM, RAW_UNDER, 16'h0010, 16'h4000, 16'hFFFF);
    add_query(RAW_MAX_MAG, 16'h8100, RAW_TOP, RAW_BOTTOM, 16'hAAAA, 16'h0001);
    add_query(RAW_ZERO, RAW_TOP, RAW_BOTTOM, RAW_NEG_BIG, 16'h9999, 16'h6666);
    add_query(POST_NULL, RAW_TOP, RAW_BOTTOM, 16'h0020, 16'h1111, 16'hEEEE);
    add_query(POST_NULL, RAW_TOP, RAW_TOP, POST_NULL, 16'h8000, 16'h8000);
    add_query(RAW_ZERO, RAW_MAX_MAG, RAW_UNDER, RAW_ZERO, 16'h8000, 16'h8000);
    add_query(POST_NULL, POST_NULL, POST_NULL, RAW_ZERO, 16'hFFFF, 16'hFFFF);
    add_query(POST_NULL, POST_NULL, POST_NULL, POST_NULL, 16'h0000, 16'h0000);
    add_query(RAW_OVER, RAW_UNDER, RAW_MAX_MAG, RAW_NEG_BIG, 16'hFFFF, 16'h0000);
    add_query(RAW_TOP, RAW_TOP, RAW_BOTTOM, RAW_BOTTOM, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      add_random_query();
    end
    total_queries = query_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken, then for every result to come back,
    // then a little longer in case the block emits a stray result.
    while (accepted_total != total_queries) @(posedge clk);
    while (results_in != accepted_total) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0 && elevation_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
